/* sv/wapc_pkg.sv */
package wapc_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;

  localparam int TILT_W   = 16;
  localparam int MUSCLE_W = 12;
  localparam int HOLD_W   = 20;
  localparam int GAIN_W   = 6;
  localparam int MOVE_W   = 22;
  localparam int FILL_W   = 3;
  localparam int WGT_W    = 3;
  // Weight total never exceeds 2+3+4+5+6.
  localparam int WT_W     = 5;
  // Weighted sum of five tilt values, signed.
  localparam int ACC_W    = 21;
  localparam int PROD_W   = ACC_W + GAIN_W + 1;
  // Magnitude of gain times weighted sum stays below 2**26.
  localparam int MAG_W    = 26;
  localparam int CNT_W    = 5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [MUSCLE_W-1:0] THRESHOLD_RST = 12'd1900;
  localparam logic [HOLD_W-1:0]   HOLDOFF_RST   = 20'd1000;
  localparam logic [GAIN_W-1:0]   GAIN_X_RST    = 6'd20;
  localparam logic [GAIN_W-1:0]   GAIN_Y_RST    = 6'd40;

  localparam logic [WGT_W-1:0] WEIGHT_BASE = 3'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_HOLDOFF   = 2'd1;
  localparam logic [1:0] REG_GAIN_X    = 2'd2;
  localparam logic [1:0] REG_GAIN_Y    = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC_X,
    S_GAIN_X,
    S_DIV_X,
    S_MAC_Y,
    S_GAIN_Y,
    S_DIV_Y,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                     start;
    logic                     negate;
    logic signed [PROD_W-1:0] dividend;
    logic [WT_W-1:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MOVE_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/wapc_div.sv */
module wapc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wapc_pkg::div_req_t req,
  output wapc_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [wapc_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [wapc_pkg::MAG_W-1:0]        quo_r, quo_nxt;
  logic [wapc_pkg::WT_W-1:0]         rem_r, rem_nxt;
  logic [wapc_pkg::WT_W-1:0]         div_r, div_nxt;
  logic                              neg_r, neg_nxt;
  logic signed [wapc_pkg::PROD_W-1:0] abs_dividend;
  logic [wapc_pkg::WT_W:0]           trial;
  logic [wapc_pkg::WT_W:0]           diff;
  logic                              fits;
  logic [wapc_pkg::MOVE_W-1:0]       quo_mag;
  logic                              last;

  assign abs_dividend = req.dividend[wapc_pkg::PROD_W-1] ? -req.dividend : req.dividend;
  assign trial = {rem_r, quo_r[wapc_pkg::MAG_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};
  assign last  = cnt_r == wapc_pkg::CNT_W'(wapc_pkg::MAG_W - 1);

  // One restoring step per cycle: shift in a dividend bit, subtract if it fits.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = abs_dividend[wapc_pkg::MAG_W-1:0];
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      neg_nxt  = req.dividend[wapc_pkg::PROD_W-1] ^ req.negate;
    end else if (busy_r) begin
      quo_nxt = {quo_r[wapc_pkg::MAG_W-2:0], fits};
      rem_nxt = fits ? diff[wapc_pkg::WT_W-1:0] : trial[wapc_pkg::WT_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign quo_mag      = quo_r[wapc_pkg::MOVE_W-1:0];
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(quo_mag) : $signed(quo_mag);

endmodule

/* sv/weighted_average_pointer_with_click.sv */
// Tilt pointer with weighted moving average and click request. A tick word
// (in_tuser = 1) gives no result and leaves the input ready. A sample word
// gives one result word, worked from the n tilt pairs held (1 to
// HISTORY_DEPTH): one shared multiplier walks the history once for X and
// once for Y, and a shared restoring divider needs 26 steps for each axis,
// with a gain step per axis and an output step at the end.
// The input is not ready while a sample is being worked on. The output
// register holds a finished result until it is taken, and the block
// accepts the next word meanwhile. The user must write registers over the
// APB port only while the block is idle; the block does not enforce this.
module weighted_average_pointer_with_click #(
  parameter int HISTORY_DEPTH = wapc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tilt_x[15:0], tilt_y[31:16], muscle_a[43:32], muscle_b[55:44]
  input  logic [wapc_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // move_x[21:0], move_y[43:22], double_click[44], zero[47:45]
  output logic [wapc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wapc_pkg::APB_AW-1:0]       cfg_paddr,
  input  logic [wapc_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic [wapc_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // Configuration registers.
  logic [wapc_pkg::MUSCLE_W-1:0] threshold_r;
  logic [wapc_pkg::HOLD_W-1:0]   holdoff_ticks_r;
  logic [wapc_pkg::GAIN_W-1:0]   gain_x_r;
  logic [wapc_pkg::GAIN_W-1:0]   gain_y_r;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  wapc_pkg::state_t state_r, state_nxt;

  logic signed [wapc_pkg::TILT_W-1:0] hist_x_r [HISTORY_DEPTH];
  logic signed [wapc_pkg::TILT_W-1:0] hist_y_r [HISTORY_DEPTH];
  logic [wapc_pkg::FILL_W-1:0]        fill_r, fill_nxt;
  logic [wapc_pkg::HOLD_W-1:0]        holdoff_r, holdoff_nxt;
  logic                               click_r, click_nxt;
  logic [wapc_pkg::FILL_W-1:0]        k_r, k_nxt;
  logic signed [wapc_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [wapc_pkg::WT_W-1:0]          wt_r, wt_nxt;
  logic signed [wapc_pkg::MOVE_W-1:0] mx_r, mx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [wapc_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  logic                               accept, sample_acc, tick_acc, full, click_req;
  logic signed [wapc_pkg::TILT_W-1:0] in_x, in_y;
  logic [wapc_pkg::MUSCLE_W-1:0]      in_ma, in_mb;
  logic [wapc_pkg::WGT_W-1:0]         weight;
  logic signed [wapc_pkg::TILT_W-1:0] tap;
  logic                               mac_last;
  logic signed [wapc_pkg::ACC_W-1:0]  mul_a;
  logic [wapc_pkg::GAIN_W-1:0]        mul_b;
  logic signed [wapc_pkg::PROD_W-1:0] product;
  logic                               out_load;

  // Sequencer controls.
  logic mac_en, mac_y, gain_en, gain_y, div_wait;

  wapc_pkg::div_req_t div_req;
  wapc_pkg::div_rsp_t div_rsp;

  // ---------------------------------------------------------------- config
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= wapc_pkg::THRESHOLD_RST;
      holdoff_ticks_r <= wapc_pkg::HOLDOFF_RST;
      gain_x_r        <= wapc_pkg::GAIN_X_RST;
      gain_y_r        <= wapc_pkg::GAIN_Y_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wapc_pkg::REG_THRESHOLD: threshold_r     <= cfg_pwdata[wapc_pkg::MUSCLE_W-1:0];
        wapc_pkg::REG_HOLDOFF:   holdoff_ticks_r <= cfg_pwdata[wapc_pkg::HOLD_W-1:0];
        wapc_pkg::REG_GAIN_X:    gain_x_r        <= cfg_pwdata[wapc_pkg::GAIN_W-1:0];
        wapc_pkg::REG_GAIN_Y:    gain_y_r        <= cfg_pwdata[wapc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wapc_pkg::REG_THRESHOLD: cfg_prdata = wapc_pkg::APB_DW'(threshold_r);
      wapc_pkg::REG_HOLDOFF:   cfg_prdata = wapc_pkg::APB_DW'(holdoff_ticks_r);
      wapc_pkg::REG_GAIN_X:    cfg_prdata = wapc_pkg::APB_DW'(gain_x_r);
      wapc_pkg::REG_GAIN_Y:    cfg_prdata = wapc_pkg::APB_DW'(gain_y_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input
  assign in_x  = in_tdata[15:0];
  assign in_y  = in_tdata[31:16];
  assign in_ma = in_tdata[43:32];
  assign in_mb = in_tdata[55:44];

  assign in_tready  = (state_r == wapc_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign sample_acc = accept && (in_tuser == wapc_pkg::CMD_SAMPLE);
  assign tick_acc   = accept && (in_tuser == wapc_pkg::CMD_TICK);
  assign full       = fill_r >= wapc_pkg::FILL_W'(HISTORY_DEPTH);
  assign click_req  = ((in_ma > threshold_r) || (in_mb > threshold_r)) && (holdoff_r == '0);

  // Once the history is full the oldest pair drops out and the rest move down.
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
    if (i == HISTORY_DEPTH - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (sample_acc && (full || fill_r == wapc_pkg::FILL_W'(i))) begin
          hist_x_r[i] <= in_x;
          hist_y_r[i] <= in_y;
        end
      end
    end else begin : g_low
      always_ff @(posedge clk) begin
        if (sample_acc) begin
          if (full) begin
            hist_x_r[i] <= hist_x_r[i+1];
            hist_y_r[i] <= hist_y_r[i+1];
          end else if (fill_r == wapc_pkg::FILL_W'(i)) begin
            hist_x_r[i] <= in_x;
            hist_y_r[i] <= in_y;
          end
        end
      end
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    holdoff_nxt = holdoff_r;
    click_nxt   = click_r;
    if (tick_acc) begin
      if (holdoff_r != '0) begin
        holdoff_nxt = holdoff_r - 1'b1;
      end
    end else if (sample_acc) begin
      if (!full) begin
        fill_nxt = fill_r + 1'b1;
      end
      click_nxt = click_req;
      if (click_req) begin
        holdoff_nxt = holdoff_ticks_r;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign mac_last = (k_r + 1'b1) == fill_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wapc_pkg::S_IDLE:   if (sample_acc) state_nxt = wapc_pkg::S_MAC_X;
      wapc_pkg::S_MAC_X:  if (mac_last) state_nxt = wapc_pkg::S_GAIN_X;
      wapc_pkg::S_GAIN_X: state_nxt = wapc_pkg::S_DIV_X;
      wapc_pkg::S_DIV_X:  if (div_rsp.done) state_nxt = wapc_pkg::S_MAC_Y;
      wapc_pkg::S_MAC_Y:  if (mac_last) state_nxt = wapc_pkg::S_GAIN_Y;
      wapc_pkg::S_GAIN_Y: state_nxt = wapc_pkg::S_DIV_Y;
      wapc_pkg::S_DIV_Y:  if (div_rsp.done) state_nxt = wapc_pkg::S_OUT;
      wapc_pkg::S_OUT:    if (!out_valid_r || out_tready) state_nxt = wapc_pkg::S_IDLE;
      default:            state_nxt = wapc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mac_en   = 1'b0;
    mac_y    = 1'b0;
    gain_en  = 1'b0;
    gain_y   = 1'b0;
    div_wait = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      wapc_pkg::S_MAC_X:  mac_en = 1'b1;
      wapc_pkg::S_MAC_Y: begin
        mac_en = 1'b1;
        mac_y  = 1'b1;
      end
      wapc_pkg::S_GAIN_X: gain_en = 1'b1;
      wapc_pkg::S_GAIN_Y: begin
        gain_en = 1'b1;
        gain_y  = 1'b1;
      end
      wapc_pkg::S_DIV_X,
      wapc_pkg::S_DIV_Y:  div_wait = 1'b1;
      wapc_pkg::S_OUT:    out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign weight = k_r + wapc_pkg::WEIGHT_BASE;
  assign tap    = mac_y ? hist_y_r[k_r[IDX_W-1:0]] : hist_x_r[k_r[IDX_W-1:0]];

  // The one multiplier serves the weighted taps and the final gain.
  assign mul_a   = gain_en ? acc_r : wapc_pkg::ACC_W'(tap);
  assign mul_b   = gain_en ? (gain_y ? gain_y_r : gain_x_r) : wapc_pkg::GAIN_W'(weight);
  assign product = mul_a * $signed({1'b0, mul_b});

  assign div_req.start    = gain_en;
  assign div_req.negate   = gain_y;
  assign div_req.dividend = product;
  assign div_req.divisor  = wt_r;

  wapc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    k_nxt   = k_r;
    acc_nxt = acc_r;
    wt_nxt  = wt_r;
    mx_nxt  = mx_r;
    if (sample_acc) begin
      k_nxt   = '0;
      acc_nxt = '0;
      wt_nxt  = '0;
    end else if (mac_en) begin
      acc_nxt = acc_r + product[wapc_pkg::ACC_W-1:0];
      k_nxt   = mac_last ? '0 : k_r + 1'b1;
      if (!mac_y) begin
        wt_nxt = wt_r + wapc_pkg::WT_W'(weight);
      end
    end else if (gain_en) begin
      acc_nxt = '0;
    end
    if (div_wait && div_rsp.done && state_r == wapc_pkg::S_DIV_X) begin
      mx_nxt = div_rsp.quotient;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, click_r, div_rsp.quotient, mx_r};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The Y quotient is held by the divider until the next start, so S_OUT may wait.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wapc_pkg::S_IDLE;
      fill_r      <= '0;
      holdoff_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      holdoff_r   <= holdoff_nxt;
      out_valid_r <= out_valid_nxt;
    end
    click_r    <= click_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    wt_r       <= wt_nxt;
    mx_r       <= mx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= wapc_pkg::FILL_W'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> !in_tready)
    else $error("input ready straight after a sample word");

  a_click_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_acc && click_req) |=> holdoff_r == $past(holdoff_ticks_r))
    else $error("hold-off not reloaded after a click");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == wapc_pkg::S_DIV_X || state_r == wapc_pkg::S_DIV_Y))
    else $error("divider finished outside a divide state");

endmodule

/* sim/tb_weighted_average_pointer_with_click.sv */
`timescale 1ns / 100ps

module tb_weighted_average_pointer_with_click;

  localparam int TOTAL_WORDS   = 1700;
  localparam int CALM_WORDS    = 250;
  localparam int SETTLE_CYCLES = 120;
  localparam int LIMIT_CYCLES  = 1000000;

  typedef struct {
    logic [wapc_pkg::MOVE_W-1:0] move_x;
    logic [wapc_pkg::MOVE_W-1:0] move_y;
    logic                        click;
  } move_t;

  // Tracks the pointer state and the moves still owed by the block.
  class click_scoreboard;
    logic [wapc_pkg::MUSCLE_W-1:0]      threshold;
    logic [wapc_pkg::HOLD_W-1:0]        holdoff;
    logic [wapc_pkg::GAIN_W-1:0]        gain_x;
    logic [wapc_pkg::GAIN_W-1:0]        gain_y;
    logic signed [wapc_pkg::TILT_W-1:0] hist_x[wapc_pkg::HISTORY_DEPTH_DEF];
    logic signed [wapc_pkg::TILT_W-1:0] hist_y[wapc_pkg::HISTORY_DEPTH_DEF];
    int                                 fill;
    logic [wapc_pkg::HOLD_W-1:0]        holdoff_left;
    move_t                              owed_moves[$];

    function new();
      threshold    = wapc_pkg::THRESHOLD_RST;
      holdoff      = wapc_pkg::HOLDOFF_RST;
      gain_x       = wapc_pkg::GAIN_X_RST;
      gain_y       = wapc_pkg::GAIN_Y_RST;
      fill         = 0;
      holdoff_left = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        wapc_pkg::REG_THRESHOLD: threshold = value[wapc_pkg::MUSCLE_W-1:0];
        wapc_pkg::REG_HOLDOFF:   holdoff   = value[wapc_pkg::HOLD_W-1:0];
        wapc_pkg::REG_GAIN_X:    gain_x    = value[wapc_pkg::GAIN_W-1:0];
        wapc_pkg::REG_GAIN_Y:    gain_y    = value[wapc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic cmd, logic [wapc_pkg::IN_DATA_W-1:0] d);
      longint sx, sy, wt, mx, my;
      logic [wapc_pkg::MUSCLE_W-1:0] ma, mb;
      move_t m;
      sx = 0;
      sy = 0;
      wt = 0;
      if (cmd == wapc_pkg::CMD_TICK) begin
        if (holdoff_left != 0) holdoff_left--;
        return;
      end
      // The history shifts once full; the newest pair sits in the last slot.
      if (fill >= wapc_pkg::HISTORY_DEPTH_DEF) begin
        for (int i = 0; i < wapc_pkg::HISTORY_DEPTH_DEF - 1; i++) begin
          hist_x[i] = hist_x[i+1];
          hist_y[i] = hist_y[i+1];
        end
        hist_x[wapc_pkg::HISTORY_DEPTH_DEF-1] = d[15:0];
        hist_y[wapc_pkg::HISTORY_DEPTH_DEF-1] = d[31:16];
      end else begin
        hist_x[fill] = d[15:0];
        hist_y[fill] = d[31:16];
        fill++;
      end
      for (int i = 0; i < fill; i++) begin
        sx += (longint'(i) + longint'(wapc_pkg::WEIGHT_BASE)) * longint'(hist_x[i]);
        sy += (longint'(i) + longint'(wapc_pkg::WEIGHT_BASE)) * longint'(hist_y[i]);
        wt += longint'(i) + longint'(wapc_pkg::WEIGHT_BASE);
      end
      mx = (longint'(gain_x) * sx) / wt;
      my = (-(longint'(gain_y) * sy)) / wt;
      ma = d[43:32];
      mb = d[55:44];
      m.move_x = mx[wapc_pkg::MOVE_W-1:0];
      m.move_y = my[wapc_pkg::MOVE_W-1:0];
      m.click  = 1'b0;
      if ((ma > threshold || mb > threshold) && holdoff_left == 0) begin
        m.click      = 1'b1;
        holdoff_left = holdoff;
      end
      owed_moves.insert(owed_moves.size(), m);
    endfunction

    function int check_word(input logic [wapc_pkg::OUT_DATA_W-1:0] w, output string why);
      move_t m;
      why = "";
      if (owed_moves.size() == 0) begin
        why = $sformatf("result word %h arrived with nothing owed", w);
        return 1;
      end
      m = owed_moves[0];
      owed_moves.delete(0);
      if (w[21:0] !== m.move_x)
        why = {why, $sformatf(" move_x %0d want %0d", $signed(w[21:0]), $signed(m.move_x))};
      if (w[43:22] !== m.move_y)
        why = {why, $sformatf(" move_y %0d want %0d", $signed(w[43:22]), $signed(m.move_y))};
      if (w[44] !== m.click)
        why = {why, $sformatf(" double_click %b want %b", w[44], m.click)};
      if (w[47:45] !== 3'b000)
        why = {why, $sformatf(" padding %b", w[47:45])};
      return (why != "") ? 1 : 0;
    endfunction

    function int outstanding();
      return owed_moves.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  // tilt_x[15:0], tilt_y[31:16], muscle_a[43:32], muscle_b[55:44]
  logic [wapc_pkg::IN_DATA_W-1:0]  in_tdata    = '0;
  // cmd[0]
  logic                            in_tuser    = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b1;
  // move_x[21:0], move_y[43:22], double_click[44], zero[47:45]
  logic [wapc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [wapc_pkg::APB_AW-1:0]     cfg_paddr   = '0;
  logic [wapc_pkg::APB_DW-1:0]     cfg_pwdata  = '0;
  logic [wapc_pkg::APB_DW-1:0]     cfg_prdata;
  logic                            cfg_pready;

  click_scoreboard sb = new();
  int  errors     = 0;
  int  words_sent = 0;
  int  cycles     = 0;
  bit  idle_on    = 1'b1;

  weighted_average_pointer_with_click DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_weighted_average_pointer_with_click: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string why);
    errors++;
    $display("mismatch at cycle %0d:%s", cycles, why);
  endtask

  // Result side: checks each word taken and stalls in short bursts.
  initial begin
    int    stall;
    string why;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (sb.check_word(out_tdata, why) != 0) report_mismatch(why);
      end
      if (stall > 0) begin
        stall--;
        if (stall == 0) out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 5);
        out_tready <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Sometimes sets bits above the register width, which must be dropped.
  function automatic logic [31:0] pad_high(input logic [31:0] value, input int width);
    if ($urandom_range(0, 3) == 0) return value | ($urandom << width);
    return value;
  endfunction

  task automatic send_word(input logic cmd, input logic [wapc_pkg::IN_DATA_W-1:0] payload);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(cmd, payload);
    words_sent++;
  endtask

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [11:0] a, input logic [11:0] b);
    send_word(wapc_pkg::CMD_SAMPLE, {b, a, y, x});
  endtask

  task automatic send_tick();
    send_word(wapc_pkg::CMD_TICK, wapc_pkg::IN_DATA_W'({$urandom, $urandom}));
  endtask

  // Waits until every owed move has come out and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_tilt();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_muscle(input logic [11:0] thr);
    int v;
    case ($urandom_range(0, 5))
      0: return 12'($urandom);
      1: return 12'hfff;
      2: return 12'h000;
      5: return 12'($urandom_range(0, thr));
      default: begin
        // Close to the threshold, on both sides of it.
        v = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
      end
    endcase
  endfunction

  task automatic random_setup();
    logic [11:0] thr;
    logic [19:0] hold;
    logic [5:0]  gx, gy;
    case ($urandom_range(0, 5))
      0: thr = 12'd0;
      1: thr = 12'hfff;
      default: thr = 12'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 9))
      0: hold = 20'd0;
      1: hold = 20'hfffff;
      2: hold = 20'($urandom);
      default: hold = 20'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0: gx = 6'd0;
      1: gx = 6'd63;
      default: gx = 6'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: gy = 6'd0;
      1: gy = 6'd63;
      default: gy = 6'($urandom);
    endcase
    write_reg(wapc_pkg::REG_THRESHOLD, pad_high(32'(thr), wapc_pkg::MUSCLE_W));
    write_reg(wapc_pkg::REG_HOLDOFF, pad_high(32'(hold), wapc_pkg::HOLD_W));
    write_reg(wapc_pkg::REG_GAIN_X, pad_high(32'(gx), wapc_pkg::GAIN_W));
    write_reg(wapc_pkg::REG_GAIN_Y, pad_high(32'(gy), wapc_pkg::GAIN_W));
  endtask

  initial begin
    int phase_len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first sample clicks at once, then the hold-off blocks.
    // The history fills from one pair to five and then starts to shift.
    send_sample(16'h7fff, 16'h8000, 12'hfff, 12'h000);
    send_sample(16'h7fff, 16'h8000, 12'h000, 12'hfff);
    send_tick();
    send_sample(16'h7fff, 16'h8000, 12'd1900, 12'd1900);
    send_sample(16'h7fff, 16'h8000, 12'd1901, 12'd0);
    send_sample(16'h7fff, 16'h8000, 12'd0, 12'd0);
    send_sample(16'h8000, 16'h7fff, 12'd0, 12'd0);
    send_sample(16'hffff, 16'h0001, 12'd0, 12'd0);
    settle();

    // Zero threshold, zero hold-off, largest gains: click on every level above 0.
    write_reg(wapc_pkg::REG_THRESHOLD, 32'd0);
    write_reg(wapc_pkg::REG_HOLDOFF, 32'd0);
    write_reg(wapc_pkg::REG_GAIN_X, 32'd63);
    write_reg(wapc_pkg::REG_GAIN_Y, 32'd63);
    send_sample(16'h8000, 16'h7fff, 12'd1, 12'd0);
    send_sample(16'h8000, 16'h7fff, 12'd0, 12'd1);
    send_sample(16'h8000, 16'h7fff, 12'd0, 12'd0);
    send_tick();
    send_sample(16'h8000, 16'h8000, 12'hfff, 12'hfff);
    send_sample(16'h7fff, 16'h7fff, 12'hfff, 12'hfff);
    settle();

    // Short hold-off counted down by ticks; no gain on X.
    write_reg(wapc_pkg::REG_THRESHOLD, 32'd2000);
    write_reg(wapc_pkg::REG_HOLDOFF, 32'd3);
    write_reg(wapc_pkg::REG_GAIN_X, 32'd0);
    write_reg(wapc_pkg::REG_GAIN_Y, 32'd1);
    send_sample(16'h1234, 16'hedcb, 12'd2001, 12'd0);
    send_sample(16'h7fff, 16'h8000, 12'hfff, 12'hfff);
    send_tick();
    send_tick();
    send_sample(16'h0000, 16'hffff, 12'd0, 12'hfff);
    send_tick();
    send_sample(16'h5555, 16'haaaa, 12'd0, 12'hfff);
    settle();

    while (words_sent < TOTAL_WORDS) begin
      random_setup();
      phase_len = $urandom_range(60, 200);
      if (phase_len > TOTAL_WORDS - words_sent) phase_len = TOTAL_WORDS - words_sent;
      repeat (phase_len) begin
        idle_on = (words_sent < TOTAL_WORDS - CALM_WORDS);
        if ($urandom_range(0, 9) < 3) send_tick();
        else send_sample(pick_tilt(), pick_tilt(), pick_muscle(sb.threshold),
                         pick_muscle(sb.threshold));
      end
      settle();
    end

    if (errors == 0 && sb.outstanding() == 0) begin
      $display("tb_weighted_average_pointer_with_click: done, clean");
    end else begin
      $display("tb_weighted_average_pointer_with_click: done, errors");
    end
    $finish;
  end

endmodule
